// ----- hw/rtl/rgba5551_horizontal_smoothing_unit_defines.svh -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef RGBA5551_HORIZONTAL_SMOOTHING_UNIT_DEFINES_SVH
`define RGBA5551_HORIZONTAL_SMOOTHING_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RHS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rhs_pkg.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing: package
// Types, frame position codes and the per-channel smoothing functions.
// ---------------------------------------------------------------------------
package rhs_pkg;

    // Frame position codes.
    localparam logic [1:0] POS_IDLE  = 2'd0;
    localparam logic [1:0] POS_FIRST = 2'd1;
    localparam logic [1:0] POS_RUN   = 2'd2;

    // Result queue depth and widths.
    localparam int unsigned FIFO_DEPTH = 4;
    localparam int unsigned PTR_W      = 2;
    localparam int unsigned CNT_W      = 3;

    // One result word.
    typedef struct packed {
        logic [15:0] pixel;
        logic        last;
    } result_t;

    // Results produced by one input word (0, 1 or 2 of them).
    typedef struct packed {
        logic [1:0] n;
        result_t    res0;
        result_t    res1;
    } push_t;

    // Queue status seen by the core and the top level.
    typedef struct packed {
        logic             room;
        logic             pop;
        logic [CNT_W-1:0] count;
    } fifo_stat_t;

    // Pack C>>1 of red, green, blue into 12 bits.
    function automatic logic [11:0] halves_of(input logic [15:0] p);
        return {p[15:12], p[10:7], p[5:2]};
    endfunction

    // Pack (C>>2)<<1 of red, green, blue into 12 bits.
    function automatic logic [11:0] edge_halves_of(input logic [15:0] p);
        return {p[15:13], 1'b0, p[10:8], 1'b0, p[5:3], 1'b0};
    endfunction

    // (hL + 2*hC + hR) >> 1 for one channel.
    function automatic logic [4:0] smooth_channel(input logic [3:0] hl,
                                                  input logic [3:0] hc,
                                                  input logic [3:0] hr);
        logic [5:0] sum;
        sum = {2'b00, hl} + {1'b0, hc, 1'b0} + {2'b00, hr};
        return sum[5:1];
    endfunction

    // Smoothed RGBA5551 pixel with alpha forced to one.
    function automatic logic [15:0] smooth(input logic [11:0] l,
                                           input logic [11:0] c,
                                           input logic [11:0] r);
        return {smooth_channel(l[11:8], c[11:8], r[11:8]),
                smooth_channel(l[7:4], c[7:4], r[7:4]),
                smooth_channel(l[3:0], c[3:0], r[3:0]),
                1'b1};
    endfunction

endpackage

// ----- hw/rtl/rhs_in_if.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing: input channel
// Valid/ready channel carrying one pixel word with its frame marks.
// ---------------------------------------------------------------------------
interface rhs_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel;
    logic        first_of_frame;
    logic        last_of_frame;

    modport source (output valid, pixel, first_of_frame, last_of_frame, input ready);
    modport sink   (input valid, pixel, first_of_frame, last_of_frame, output ready);
endinterface

// ----- hw/rtl/rhs_out_if.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing: output channel
// Valid/ready channel carrying one result pixel word and its frame end mark.
// ---------------------------------------------------------------------------
interface rhs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_out;
    logic        last_out;

    modport source (output valid, pixel_out, last_out, input ready);
    modport sink   (input valid, pixel_out, last_out, output ready);
endinterface

// ----- hw/rtl/rhs_out_fifo.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing: result queue
// Four-word queue that takes up to two result words a cycle and hands one
// word a cycle to the output channel while the channel is ready.
// ---------------------------------------------------------------------------
module rhs_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  rhs_pkg::push_t      push,
    output rhs_pkg::fifo_stat_t stat,
    rhs_out_if.source           pix_out
);

    rhs_pkg::result_t                    mem [rhs_pkg::FIFO_DEPTH];
    logic [rhs_pkg::PTR_W-1:0]           wr_ptr_reg;
    logic [rhs_pkg::PTR_W-1:0]           wr_ptr_next;
    logic [rhs_pkg::PTR_W-1:0]           rd_ptr_reg;
    logic [rhs_pkg::PTR_W-1:0]           rd_ptr_next;
    logic [rhs_pkg::CNT_W-1:0]           count_reg;
    logic [rhs_pkg::CNT_W-1:0]           count_next;
    logic [rhs_pkg::PTR_W-1:0]           wr_ptr_plus1;
    logic                                pop;
    rhs_pkg::result_t                    head;

    // The head word drives the output channel.
    assign head              = mem[rd_ptr_reg];
    assign pix_out.valid     = (count_reg != '0);
    assign pix_out.pixel_out = head.pixel;
    assign pix_out.last_out  = head.last;
    assign pop               = pix_out.valid && pix_out.ready;

    // Room for two more words, counted before this cycle's pop.
    assign stat.room  = (count_reg <= rhs_pkg::CNT_W'(rhs_pkg::FIFO_DEPTH - 2));
    assign stat.pop   = pop;
    assign stat.count = count_reg;

    // Pointer and fill count updates.
    assign wr_ptr_plus1 = wr_ptr_reg + rhs_pkg::PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + rhs_pkg::PTR_W'(push.n);
    assign rd_ptr_next  = rd_ptr_reg + rhs_pkg::PTR_W'(pop);
    assign count_next   = count_reg + rhs_pkg::CNT_W'(push.n)
                          - rhs_pkg::CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes: first word at the write pointer, second just after it.
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_ptr_plus1] <= push.res1;
        end
    end

endmodule

// ----- hw/rtl/rhs_core.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing: filter core
// Input register, neighbor halves and frame position, and the 1-2-1 filter
// that turns one input word into zero, one or two result words.
// ---------------------------------------------------------------------------
module rhs_core (
    input  logic                clk,
    input  logic                rst_n,
    rhs_in_if.sink              pix_in,
    input  rhs_pkg::fifo_stat_t stat,
    output rhs_pkg::push_t      push
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [15:0] in_pixel_reg;
    logic        in_first_reg;
    logic        in_last_reg;
    logic [11:0] left_reg;
    logic [11:0] left_next;
    logic [11:0] center_reg;
    logic [11:0] center_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        go;
    logic        take;
    logic [11:0] halves;

    // The held word is processed once the queue has room for two words.
    assign go            = in_valid_reg && stat.room;
    assign pix_in.ready  = !in_valid_reg || go;
    assign take          = pix_in.valid && pix_in.ready;
    assign in_valid_next = take || (in_valid_reg && !go);
    assign halves        = rhs_pkg::halves_of(in_pixel_reg);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_pixel_reg <= pix_in.pixel;
            in_first_reg <= pix_in.first_of_frame;
            in_last_reg  <= pix_in.last_of_frame;
        end
    end

    // Frame state and results for the held word.
    always_comb
    begin
        left_next   = left_reg;
        center_next = center_reg;
        pos_next    = pos_reg;
        push.n      = 2'd0;
        push.res0   = '{pixel: in_pixel_reg, last: in_last_reg};
        push.res1   = '{pixel: in_pixel_reg, last: 1'b1};
        if (go)
        begin
            priority if (in_first_reg)
            begin
                // A frame start passes through and opens a new frame unless also last.
                push.n    = 2'd1;
                left_next = rhs_pkg::edge_halves_of(in_pixel_reg);
                pos_next  = in_last_reg ? rhs_pkg::POS_IDLE : rhs_pkg::POS_FIRST;
            end
            else if (pos_reg == rhs_pkg::POS_IDLE)
            begin
                // No frame open: the word is dropped.
                push.n = 2'd0;
            end
            else if (pos_reg == rhs_pkg::POS_FIRST)
            begin
                // Second pixel: its halves are kept; a last one is also passed through.
                center_next = halves;
                pos_next    = in_last_reg ? rhs_pkg::POS_IDLE : rhs_pkg::POS_RUN;
                push.n      = in_last_reg ? 2'd1 : 2'd0;
                push.res0   = '{pixel: in_pixel_reg, last: 1'b1};
            end
            else
            begin
                // Running: emit the smoothed center, then the frame end if marked.
                left_next   = center_reg;
                center_next = halves;
                push.res0   = '{pixel: rhs_pkg::smooth(left_reg, center_reg, halves),
                                last: 1'b0};
                push.n      = in_last_reg ? 2'd2 : 2'd1;
                pos_next    = in_last_reg ? rhs_pkg::POS_IDLE : rhs_pkg::POS_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            center_reg <= '0;
            pos_reg    <= rhs_pkg::POS_IDLE;
        end
        else
        begin
            left_reg   <= left_next;
            center_reg <= center_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

// ----- hw/rtl/rgba5551_horizontal_smoothing_unit.sv -----
// ---------------------------------------------------------------------------
// RGBA5551 horizontal smoothing unit
// Horizontal 1-2-1 smoothing of a frame of RGBA5551 pixels sent as one line.
// ---------------------------------------------------------------------------
// Use of the block:
// pix_in takes one word per ready cycle with first_of_frame and last_of_frame
// marks; pix_out delivers result words with last_out on the frame's final word.
// The first pixel goes out at once, each pixel after the second releases the
// smoothed previous pixel, and the last pixel also releases itself unchanged.
// Words without an open frame and without a first mark are dropped.
// Results pass the input register and then the queue on their way to pix_out.
// Throughput: one input word per cycle while the queue has room; a last word
// from the third pixel on yields two result words, drained one per ready cycle.
// Input words wait in an input register and their results in a four-word
// queue; pix_in.ready drops only when the queue lacks room for two words.
// When the receiver stalls, the queue holds its words and the input side keeps
// taking words until the queue lacks room for two.
// Reset empties the queue, clears the input register and closes any frame.
// ---------------------------------------------------------------------------
`include "rgba5551_horizontal_smoothing_unit_defines.svh"

module rgba5551_horizontal_smoothing_unit (
    input  logic      clk,
    input  logic      rst_n,
    rhs_in_if.sink    pix_in,
    rhs_out_if.source pix_out
);

    rhs_pkg::push_t      push;
    rhs_pkg::fifo_stat_t stat;

    // Filter core with input register and frame state.
    rhs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in),
        .stat   (stat),
        .push   (push)
    );

    // Result queue feeding the output channel.
    rhs_out_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .stat    (stat),
        .pix_out (pix_out)
    );

    // The core only pushes words when the queue has room for two.
    `RHS_ASSERT_SAME(a_push_room, push.n != 2'd0, stat.room, "push without queue room")

    // The fill count follows pushes and pops exactly.
    `RHS_ASSERT_NEXT(a_count_track, 1'b1,
        stat.count == $past(stat.count) + 3'($past(push.n)) - 3'($past(stat.pop)),
        "queue count mismatch")

    // A double push is a smoothed word followed by the frame end word.
    `RHS_ASSERT_SAME(a_double_push, push.n == 2'd2,
        push.res1.last && !push.res0.last && push.res0.pixel[0],
        "bad double push")

endmodule
